// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl files, included by hafb_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hafb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafb_pkg
// Shared sizes, codes and types of the hole allocator.
// ----------------------------------------------------------------------------
package hafb_pkg;

    localparam int HOLE_COUNT   = 16;
    localparam int SIZE_WIDTH   = 16;

    // fixed widths of the interface fields
    localparam int HINDEX_W     = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int HIU_W        = 5;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 5;

    localparam int IDX_W = (HOLE_COUNT > 1) ? $clog2(HOLE_COUNT) : 1;
    localparam int CNT_W = $clog2(HOLE_COUNT + 1);
    localparam int CMP_W = (CNT_W > HIU_W) ? CNT_W : HIU_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLES_IN_USE = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    typedef struct packed {
        logic             fit_policy;
        logic [HIU_W-1:0] holes_in_use;
    } t_cfg;

    typedef struct packed {
        logic                    granted;
        logic [HINDEX_W-1:0]     hole_number;
        logic [SIZE_FIELD_W-1:0] remaining_size;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

// ===== hw/rtl/hafb_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafb_engine
// Hole table memory with the load, scan and write-back sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hafb_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hafb_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic [hafb_pkg::HINDEX_W-1:0]     i_hole_index,
    input  logic [hafb_pkg::SIZE_FIELD_W-1:0] i_size_value,
    output hafb_pkg::t_push                   o_push,
    input  logic                              i_push_ready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [hafb_pkg::SIZE_WIDTH-1:0] r_mem [hafb_pkg::HOLE_COUNT];
    logic [hafb_pkg::SIZE_WIDTH-1:0] r_rd_data;

    logic                            r_policy;
    logic [hafb_pkg::CNT_W-1:0]      r_limit;
    logic [hafb_pkg::SIZE_WIDTH-1:0] r_req_size;
    logic [hafb_pkg::IDX_W-1:0]      r_rd_idx;
    logic                            r_found, n_found;
    logic [hafb_pkg::IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [hafb_pkg::SIZE_WIDTH-1:0] r_best_size, n_best_size;
    hafb_pkg::t_result               r_res;

    logic                            in_fire;
    logic [hafb_pkg::SIZE_WIDTH-1:0] in_size;
    logic [hafb_pkg::CMP_W-1:0]      hiu_ext;
    logic [hafb_pkg::CNT_W-1:0]      limit_sat;
    logic                            load_in_range;
    logic                            fit, take, last, scan_done;
    logic [hafb_pkg::SIZE_WIDTH-1:0] remain;

    logic                            mem_we;
    logic [hafb_pkg::IDX_W-1:0]      mem_waddr;
    logic [hafb_pkg::SIZE_WIDTH-1:0] mem_wdata;
    logic [hafb_pkg::IDX_W-1:0]      rd_addr;

    assign o_ready = (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;
    assign in_size = hafb_pkg::SIZE_WIDTH'(i_size_value);

    assign hiu_ext   = hafb_pkg::CMP_W'(i_cfg.holes_in_use);
    assign limit_sat = (hiu_ext > hafb_pkg::CMP_W'(hafb_pkg::HOLE_COUNT))
                     ? hafb_pkg::CNT_W'(hafb_pkg::HOLE_COUNT)
                     : hafb_pkg::CNT_W'(hiu_ext);

    assign load_in_range = (hafb_pkg::CMP_W'(i_hole_index)
                            < hafb_pkg::CMP_W'(hafb_pkg::HOLE_COUNT));

    // scan step on the entry whose data is in the read register
    assign fit  = (r_rd_data >= r_req_size);
    assign take = fit && (!r_found || ((r_policy == hafb_pkg::POLICY_BEST)
                                       && (r_rd_data < r_best_size)));
    assign last = ((hafb_pkg::CNT_W'(r_rd_idx) + hafb_pkg::CNT_W'(1)) == r_limit);
    assign scan_done = last || (take && (r_policy == hafb_pkg::POLICY_FIRST));

    assign n_found     = r_found || take;
    assign n_best_idx  = take ? r_rd_idx : r_best_idx;
    assign n_best_size = take ? r_rd_data : r_best_size;

    assign remain = r_best_size - r_req_size;

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = hafb_pkg::IDX_W'(i_hole_index);
        mem_wdata = in_size;
        rd_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_req_type == hafb_pkg::REQ_LOAD) begin
                        mem_we  = load_in_range;
                        n_state = S_PUSH;
                    end else if (limit_sat == '0) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_addr = r_rd_idx + hafb_pkg::IDX_W'(1);
                if (scan_done) begin
                    n_state = n_found ? S_WRITE : S_PUSH;
                end
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_best_idx;
                mem_wdata = remain;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_policy   <= i_cfg.fit_policy;
            r_limit    <= limit_sat;
            r_req_size <= in_size;
            r_rd_idx   <= '0;
            if (i_req_type == hafb_pkg::REQ_LOAD) begin
                r_res.granted        <= 1'b0;
                r_res.hole_number    <= i_hole_index;
                r_res.remaining_size <= hafb_pkg::SIZE_FIELD_W'(in_size);
            end else begin
                r_res <= '0;
            end
        end
        if (r_state == S_SCAN) begin
            r_rd_idx    <= r_rd_idx + hafb_pkg::IDX_W'(1);
            r_best_idx  <= n_best_idx;
            r_best_size <= n_best_size;
            if (scan_done && !n_found) begin
                r_res <= '0;
            end
        end
        if (r_state == S_WRITE) begin
            r_res.granted        <= 1'b1;
            r_res.hole_number    <= hafb_pkg::HINDEX_W'(r_best_idx);
            r_res.remaining_size <= hafb_pkg::SIZE_FIELD_W'(remain);
        end
    end

    // hole table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_push.valid = (r_state == S_PUSH);
    assign o_push.data  = r_res;

    `ASSERT_IMPL(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !mem_we,
        "table written during a scan")
    `ASSERT_IMPL(a_write_needs_hit, i_clk, i_rst_n, r_state == S_WRITE, r_found,
        "write-back without a fitting hole")
    `ASSERT_IMPL(a_scan_in_limit, i_clk, i_rst_n, r_state == S_SCAN,
        hafb_pkg::CNT_W'(r_rd_idx) < r_limit, "scan ran past the holes in use")

endmodule

// ===== hw/rtl/hafb_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafb_out_buf
// One-entry result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module hafb_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hafb_pkg::t_push   i_push,
    output logic              o_push_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output hafb_pkg::t_result o_data
);

    logic              r_valid;
    hafb_pkg::t_result r_data;

    // free slot, or the held result leaves in this cycle
    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid && o_push_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid && o_push_ready) begin
            r_data <= i_push.data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/hole_allocator_first_best_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_allocator_first_best_fit
// Hole table allocator with first-fit and best-fit placement.
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_ready   i_req_type, i_hole_index, i_size_value
//   result   out        o_valid / i_ready   o_granted, o_hole_number, o_remaining_size
//   config   in         i_cfg_we            i_cfg_addr, i_cfg_data
//
// a load writes the table in the accept cycle, then pushes the result; an allocate
// scans the holes in use with one table read per cycle, then does a write-back
// on a hit and the push; a miss skips the write-back, first fit ends the scan at
// the first hit, and no holes in use skips the scan; the push waits while the
// result register stays full
// synchronous active-low reset clears control state; the table is not cleared
// ----------------------------------------------------------------------------
module hole_allocator_first_best_fit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hafb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [hafb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic [hafb_pkg::HINDEX_W-1:0]       i_hole_index,
    input  logic [hafb_pkg::SIZE_FIELD_W-1:0]   i_size_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_granted,
    output logic [hafb_pkg::HINDEX_W-1:0]       o_hole_number,
    output logic [hafb_pkg::SIZE_FIELD_W-1:0]   o_remaining_size
);

    hafb_pkg::t_cfg    r_cfg;
    hafb_pkg::t_push   push;
    logic              push_ready;
    hafb_pkg::t_result out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hafb_pkg::CFG_FIT_POLICY: begin
                    r_cfg.fit_policy <= i_cfg_data[0];
                end
                hafb_pkg::CFG_HOLES_IN_USE: begin
                    r_cfg.holes_in_use <= hafb_pkg::HIU_W'(i_cfg_data);
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    hafb_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_hole_index (i_hole_index),
        .i_size_value (i_size_value),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    hafb_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (out_data)
    );

    assign o_granted        = out_data.granted;
    assign o_hole_number    = out_data.hole_number;
    assign o_remaining_size = out_data.remaining_size;

endmodule
